FILE: hw/rtl/halfband_decimator_by_two_defines.svh
// assertion macros for the half-band decimator
`ifndef HALFBAND_DECIMATOR_BY_TWO_DEFINES_SVH
`define HALFBAND_DECIMATOR_BY_TWO_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HBD_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hbd assertion failed");

// next-cycle implication, checked out of reset
`define HBD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hbd assertion failed");

`endif

FILE: hw/rtl/hbd_pkg.sv
// shared constants, coefficient tables and coefficient rounding for the decimator
`timescale 1ns / 1ps
package hbd_pkg;

  localparam int Q_WIDTH     = 24;
  localparam int NUM_PAIRS   = 8;
  localparam int NUM_TERMS   = NUM_PAIRS + 1;
  localparam int CENTRE_TERM = NUM_PAIRS;
  localparam int PIPE_STAGES = 7;
  localparam int FIFO_DEPTH  = 8;

  // q1.23 side taps by odd distance 1, 3, ... 15 from the centre
  localparam logic signed [Q_WIDTH-1:0] SIDE_Q23 [2][NUM_PAIRS] = '{
    '{24'sd2658568, -24'sd855579, 24'sd478067, -24'sd306033,
      24'sd204489, -24'sd136936, 24'sd89490, -24'sd85841},
    '{24'sd2650314, -24'sd822218, 24'sd425462, -24'sd240560,
      24'sd133772, -24'sd69139, 24'sd32397, -24'sd15838}
  };

  localparam logic signed [Q_WIDTH-1:0] CENTRE_Q23 [2] = '{24'sd4194379, 24'sd4200226};

  // coefficient for a term, rounded to cw bits (add half, floor shift)
  function automatic logic signed [Q_WIDTH-1:0] coef_q(logic sel, int unsigned idx, int cw);
    logic signed [Q_WIDTH:0] q;
    logic signed [Q_WIDTH-1:0] raw;
    if (idx >= NUM_PAIRS) begin
      raw = CENTRE_Q23[sel];
    end else begin
      raw = SIDE_Q23[sel][3'(idx)];
    end
    q = {raw[Q_WIDTH-1], raw};
    if (cw < Q_WIDTH) begin
      q = (q + ((Q_WIDTH+1)'(1) <<< (Q_WIDTH - 1 - cw))) >>> (Q_WIDTH - cw);
    end
    return Q_WIDTH'(q);
  endfunction

endpackage

FILE: hw/rtl/hbd_cell.sv
// one delay-line cell holding an i/q sample pair, shifted from its neighbor
`timescale 1ns / 1ps
module hbd_cell #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           shift_en,
  input  logic signed [SAMPLE_WIDTH-1:0] nxt_i,
  input  logic signed [SAMPLE_WIDTH-1:0] nxt_q,
  output logic signed [SAMPLE_WIDTH-1:0] tap_i,
  output logic signed [SAMPLE_WIDTH-1:0] tap_q
);

  logic signed [SAMPLE_WIDTH-1:0] tap_i_r;
  logic signed [SAMPLE_WIDTH-1:0] tap_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_i_r <= '0;
      tap_q_r <= '0;
    end else if (shift_en) begin
      tap_i_r <= nxt_i;
      tap_q_r <= nxt_q;
    end
  end

  assign tap_i = tap_i_r;
  assign tap_q = tap_q_r;

endmodule

FILE: hw/rtl/hbd_tap_sum.sv
// pipelined symmetric pre-add, multiply, adder tree, rounding and saturation
`timescale 1ns / 1ps
module hbd_tap_sum import hbd_pkg::*; #(
  parameter int TAP_COUNT    = 31,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16
) (
  input  logic                           clk,
  input  logic                           coef_set,
  input  logic signed [SAMPLE_WIDTH-1:0] taps [TAP_COUNT],
  output logic signed [SAMPLE_WIDTH-1:0] y_r
);

  localparam int CENTRE = (TAP_COUNT - 1) / 2;
  localparam int PRE_W  = SAMPLE_WIDTH + 1;
  localparam int PROD_W = PRE_W + COEF_WIDTH;
  localparam int ACC_W  = PROD_W + 4;

  localparam logic signed [ACC_W:0] RND_HALF = (ACC_W+1)'(1) << (COEF_WIDTH - 2);
  localparam logic signed [ACC_W:0] SAT_HI   = ((ACC_W+1)'(1) << (SAMPLE_WIDTH - 1)) - 1;
  localparam logic signed [ACC_W:0] SAT_LO   = ~SAT_HI;

  logic signed [PRE_W-1:0]      pre_nxt [NUM_TERMS];
  logic signed [PRE_W-1:0]      pre_r   [NUM_TERMS];
  logic signed [COEF_WIDTH-1:0] coef    [NUM_TERMS];
  logic signed [PROD_W-1:0]     prod_r  [NUM_TERMS];
  logic signed [ACC_W-1:0]      l1_r    [5];
  logic signed [ACC_W-1:0]      l2_r    [3];
  logic signed [ACC_W-1:0]      l3_r    [2];
  logic signed [ACC_W-1:0]      acc_r;
  logic signed [ACC_W:0]        rnd;
  logic signed [ACC_W:0]        shifted;
  logic signed [SAMPLE_WIDTH-1:0] y_nxt;

  genvar j;
  for (j = 0; j < NUM_PAIRS; j++) begin : g_pair
    localparam int DIST = 2 * j + 1;
    if (DIST <= CENTRE && (CENTRE % 2) == 1) begin : g_on
      assign pre_nxt[j] = {taps[CENTRE-DIST][SAMPLE_WIDTH-1], taps[CENTRE-DIST]}
                        + {taps[CENTRE+DIST][SAMPLE_WIDTH-1], taps[CENTRE+DIST]};
      assign coef[j]    = COEF_WIDTH'(coef_q(coef_set, j, COEF_WIDTH));
    end else begin : g_off
      assign pre_nxt[j] = '0;
      assign coef[j]    = '0;
    end
  end

  assign pre_nxt[CENTRE_TERM] = {taps[CENTRE][SAMPLE_WIDTH-1], taps[CENTRE]};
  assign coef[CENTRE_TERM]    = COEF_WIDTH'(coef_q(coef_set, CENTRE_TERM, COEF_WIDTH));

  always_comb begin
    rnd     = {acc_r[ACC_W-1], acc_r} + RND_HALF;
    shifted = rnd >>> (COEF_WIDTH - 1);
    if (shifted > SAT_HI) begin
      y_nxt = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (shifted < SAT_LO) begin
      y_nxt = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      y_nxt = shifted[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < NUM_TERMS; t++) begin
      pre_r[t]  <= pre_nxt[t];
      prod_r[t] <= pre_r[t] * coef[t];
    end
    for (int t = 0; t < 4; t++) begin
      l1_r[t] <= ACC_W'(prod_r[2*t]) + ACC_W'(prod_r[2*t+1]);
    end
    l1_r[4] <= ACC_W'(prod_r[CENTRE_TERM]);
    l2_r[0] <= l1_r[0] + l1_r[1];
    l2_r[1] <= l1_r[2] + l1_r[3];
    l2_r[2] <= l1_r[4];
    l3_r[0] <= l2_r[0] + l2_r[1];
    l3_r[1] <= l2_r[2];
    acc_r   <= l3_r[0] + l3_r[1];
    y_r     <= y_nxt;
  end

endmodule

FILE: hw/rtl/hbd_out_fifo.sv
// small result fifo between the filter pipeline and the output channel
`timescale 1ns / 1ps
module hbd_out_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] data
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  assign valid = (cnt_r != '0);
  assign data  = mem_r[rd_ptr_r];

endmodule

FILE: hw/rtl/halfband_decimator_by_two.sv
// top level: half-band fir decimator by two for blocked complex i/q samples
// the result a request completes passes the delay line, the filter pipeline and the result fifo before out_valid
// throughput: one input request per cycle while the result fifo has room and no block flush is in progress
// a block end that still owes outputs holds input while zeros are flushed through the cell chain
// reset: synchronous rst_n clears delay line, counters, fifo and selects the remez set
`timescale 1ns / 1ps
`include "halfband_decimator_by_two_defines.svh"
module halfband_decimator_by_two import hbd_pkg::*; #(
  parameter int TAP_COUNT    = 31,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16,
  parameter int BLOCK_LIMIT  = 65536
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_q,
  input  logic                           in_block_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_q,
  output logic                           out_last
);

  localparam int POS_W  = $clog2(BLOCK_LIMIT + TAP_COUNT);
  localparam int OUT_W  = $clog2(BLOCK_LIMIT / 2 + 1);
  localparam int OCC_W  = $clog2(FIFO_DEPTH) + 1;
  localparam int ITEM_W = 2 * SAMPLE_WIDTH + 1;
  localparam logic TAP_PAR = 1'((TAP_COUNT - 1) % 2);

  typedef enum logic {
    S_RUN,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic vld;
    logic last;
  } tok_t;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [OUT_W-1:0] cnt_r, cnt_nxt;
  logic [OUT_W-1:0] total_r, total_nxt;
  logic [OCC_W-1:0] occ_r;
  logic             coef_set_r;
  tok_t             tok_r [PIPE_STAGES+1];

  logic             step_ok;
  logic             in_acc;
  logic             out_acc;
  logic             flush_step;
  logic             shift_en;
  logic             hit;
  logic             blk_end;
  logic [OUT_W-1:0] cnt_inc;
  logic [POS_W:0]   pos_inc;
  logic [OUT_W-1:0] blk_total;
  logic             emit;
  logic             emit_last;

  logic signed [SAMPLE_WIDTH-1:0] tap_i [TAP_COUNT];
  logic signed [SAMPLE_WIDTH-1:0] tap_q [TAP_COUNT];
  logic signed [SAMPLE_WIDTH-1:0] y_i;
  logic signed [SAMPLE_WIDTH-1:0] y_q;
  logic [ITEM_W-1:0]              fifo_data;

  always_comb begin
    step_ok    = (occ_r < OCC_W'(FIFO_DEPTH));
    in_stall   = (state_r != S_RUN) || !step_ok;
    in_acc     = in_valid && !in_stall;
    out_acc    = out_valid && !out_stall;
    flush_step = (state_r == S_FLUSH) && step_ok;
    shift_en   = in_acc || flush_step;
    hit        = (pos_r >= POS_W'(TAP_COUNT - 1)) && (pos_r[0] == TAP_PAR);
    blk_end    = in_block_end || (pos_r >= POS_W'(BLOCK_LIMIT - 1));
    cnt_inc    = cnt_r + OUT_W'(hit);
    pos_inc    = {1'b0, pos_r} + 1'b1;
    blk_total  = OUT_W'(pos_inc >> 1);
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    emit      = 1'b0;
    emit_last = 1'b0;
    unique case (state_r)
      S_RUN: begin
        if (in_acc) begin
          emit = hit;
          if (!blk_end) begin
            pos_nxt = pos_r + 1'b1;
            cnt_nxt = cnt_inc;
          end else if (cnt_inc == blk_total) begin
            emit_last = hit;
            pos_nxt   = '0;
            cnt_nxt   = '0;
          end else begin
            total_nxt = blk_total;
            cnt_nxt   = cnt_inc;
            pos_nxt   = pos_r + 1'b1;
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (flush_step) begin
          emit = hit;
          if (hit && cnt_inc == total_r) begin
            emit_last = 1'b1;
            pos_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_RUN;
          end else begin
            pos_nxt = pos_r + 1'b1;
            cnt_nxt = cnt_inc;
          end
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_RUN;
      pos_r      <= '0;
      cnt_r      <= '0;
      total_r    <= '0;
      occ_r      <= '0;
      coef_set_r <= 1'b0;
      for (int s = 0; s <= PIPE_STAGES; s++) begin
        tok_r[s] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      occ_r   <= occ_r + OCC_W'(emit) - OCC_W'(out_acc);
      if (cfg_wr_en) begin
        coef_set_r <= cfg_wr_data;
      end
      tok_r[0] <= '{vld: emit, last: emit_last};
      for (int s = 1; s <= PIPE_STAGES; s++) begin
        tok_r[s] <= tok_r[s-1];
      end
    end
  end

  genvar k;
  for (k = 0; k < TAP_COUNT; k++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] nxt_i;
    logic signed [SAMPLE_WIDTH-1:0] nxt_q;
    if (k == TAP_COUNT - 1) begin : g_head
      assign nxt_i = in_acc ? in_sample_i : '0;
      assign nxt_q = in_acc ? in_sample_q : '0;
    end else begin : g_body
      assign nxt_i = tap_i[k+1];
      assign nxt_q = tap_q[k+1];
    end
    hbd_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .nxt_i    (nxt_i),
      .nxt_q    (nxt_q),
      .tap_i    (tap_i[k]),
      .tap_q    (tap_q[k])
    );
  end

  hbd_tap_sum #(
    .TAP_COUNT    (TAP_COUNT),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_sum_i (
    .clk      (clk),
    .coef_set (coef_set_r),
    .taps     (tap_i),
    .y_r      (y_i)
  );

  hbd_tap_sum #(
    .TAP_COUNT    (TAP_COUNT),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_sum_q (
    .clk      (clk),
    .coef_set (coef_set_r),
    .taps     (tap_q),
    .y_r      (y_q)
  );

  hbd_out_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tok_r[PIPE_STAGES].vld),
    .push_data ({y_i, y_q, tok_r[PIPE_STAGES].last}),
    .pop       (out_acc),
    .valid     (out_valid),
    .data      (fifo_data)
  );

  assign out_i    = fifo_data[ITEM_W-1 -: SAMPLE_WIDTH];
  assign out_q    = fifo_data[SAMPLE_WIDTH:1];
  assign out_last = fifo_data[0];

  `HBD_ASSERT_IMPLIES(a_occ_bound, 1'b1, occ_r <= OCC_W'(FIFO_DEPTH))
  `HBD_ASSERT_IMPLIES(a_out_counted, out_valid, occ_r != '0)
  `HBD_ASSERT_IMPLIES(a_flush_count, state_r == S_FLUSH, cnt_r < total_r)
  `HBD_ASSERT_NEXT(a_flush_hold, (state_r == S_FLUSH) && !step_ok, $stable(pos_r))

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the half-band decimator by two
`timescale 1ns / 1ps
module testbench;

  localparam int TAPS           = 31;
  localparam int MID_TAP        = 15;
  localparam int BLOCK_MAX      = 65536;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 64;
  localparam logic REMEZ_SET    = 1'b0;
  localparam logic FIRWIN_SET   = 1'b1;

  typedef struct {
    logic signed [15:0] i;
    logic signed [15:0] q;
    logic               last;
  } iq_result_t;

  typedef struct {
    logic signed [15:0] i;
    logic signed [15:0] q;
    logic               blk_end;
    bit                 typed;
    iq_result_t         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_sample_i = '0;
  logic signed [15:0] in_sample_q = '0;
  logic in_block_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_i;
  logic signed [15:0] out_q;
  logic out_last;

  halfband_decimator_by_two u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_i  (in_sample_i),
    .in_sample_q  (in_sample_q),
    .in_block_end (in_block_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_i        (out_i),
    .out_q        (out_q),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  // q1.23 odd-distance taps (1, 3, ... 15 from the middle) and middle tap, per set
  longint odd_tap_q23 [2][8] = '{
    '{2658568, -855579, 478067, -306033, 204489, -136936, 89490, -85841},
    '{2650314, -822218, 425462, -240560, 133772, -69139, 32397, -15838}
  };
  longint mid_tap_q23 [2] = '{4194379, 4200226};

  logic signed [15:0] line_i [TAPS] = '{default: '0};
  logic signed [15:0] line_q [TAPS] = '{default: '0};
  int unsigned blk_samples = 0;
  int unsigned blk_outputs = 0;
  logic coef_set = REMEZ_SET;

  iq_result_t pending_outputs [$];
  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_blocks = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit held_off = 1'b0;

  stim_row_t directed_rows [23] = '{
    '{32767, -32768, 1'b1, 1'b0, '{0, 0, 1'b0}},
    '{0, 0, 1'b0, 1'b0, '{0, 0, 1'b0}},
    '{0, 0, 1'b1, 1'b1, '{0, 0, 1'b1}},
    '{-32768, 32767, 1'b0, 1'b0, '{0, 0, 1'b0}},
    '{32767, -32768, 1'b0, 1'b0, '{0, 0, 1'b0}},
    '{-1, 1, 1'b1, 1'b0, '{0, 0, 1'b0}},
    '{12345, -12345, 1'b0, 1'b0, '{0, 0, 1'b0}},
    '{-32768, -32768, 1'b1, 1'b0, '{0, 0, 1'b0}},
    '{32767, 32767, 1'b0, 1'b0, '{0, 0, 1'b0}},
    '{32767, 32767, 1'b0, 1'b0, '{0, 0, 1'b0}},
    '{32767, 32767, 1'b0, 1'b0, '{0, 0, 1'b0}},
    '{32767, 32767, 1'b1, 1'b0, '{0, 0, 1'b0}},
    '{1, -1, 1'b0, 1'b0, '{0, 0, 1'b0}},
    '{-2, 2, 1'b0, 1'b0, '{0, 0, 1'b0}},
    '{21845, -21846, 1'b0, 1'b0, '{0, 0, 1'b0}},
    '{-21846, 21845, 1'b1, 1'b0, '{0, 0, 1'b0}},
    '{-32768, -32768, 1'b0, 1'b0, '{0, 0, 1'b0}},
    '{-32768, -32768, 1'b0, 1'b0, '{0, 0, 1'b0}},
    '{-32768, -32768, 1'b0, 1'b0, '{0, 0, 1'b0}},
    '{-32768, -32768, 1'b0, 1'b0, '{0, 0, 1'b0}},
    '{-32768, -32768, 1'b1, 1'b0, '{0, 0, 1'b0}},
    '{0, 0, 1'b0, 1'b0, '{0, 0, 1'b0}},
    '{0, 0, 1'b1, 1'b1, '{0, 0, 1'b1}}
  };

  function automatic longint tap_weight(int k);
    int d;
    longint raw;
    d = (k > MID_TAP) ? k - MID_TAP : MID_TAP - k;
    if (d == 0) begin
      raw = mid_tap_q23[coef_set];
    end else if ((k % 2) != 0 || (d % 2) == 0) begin
      return 0;
    end else begin
      raw = odd_tap_q23[coef_set][(d - 1) / 2];
    end
    // round to q1.15
    return (raw + 128) >>> 8;
  endfunction

  function automatic logic signed [15:0] tap_sum(bit use_q);
    longint acc;
    longint y;
    acc = 0;
    for (int k = 0; k < TAPS; k++) begin
      acc += tap_weight(k) * longint'(use_q ? line_q[k] : line_i[k]);
    end
    y = (acc + 64'sd16384) >>> 15;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y[15:0];
  endfunction

  function automatic void shift_line(logic signed [15:0] si, logic signed [15:0] sq);
    for (int k = 0; k < TAPS - 1; k++) begin
      line_i[k] = line_i[k + 1];
      line_q[k] = line_q[k + 1];
    end
    line_i[TAPS - 1] = si;
    line_q[TAPS - 1] = sq;
  endfunction

  function automatic void emit_output(logic last);
    iq_result_t r;
    r.i = tap_sum(1'b0);
    r.q = tap_sum(1'b1);
    r.last = last;
    pending_outputs.push_back(r);
  endfunction

  function automatic void decimate_sample(logic signed [15:0] si, logic signed [15:0] sq,
                                          logic blk_end);
    int unsigned m;
    int unsigned pos;
    int unsigned total;
    bit closes;
    m = blk_samples;
    pos = m;
    closes = blk_end || (m >= BLOCK_MAX - 1);
    shift_line(si, sq);
    if (!closes) begin
      if (m >= TAPS - 1 && ((m - (TAPS - 1)) % 2) == 0) begin
        emit_output(1'b0);
        blk_outputs++;
      end
      blk_samples = m + 1;
    end else begin
      // zero flush of the outputs still owed by this block
      total = (m + 1) / 2;
      for (int unsigned o = blk_outputs; o < total; o++) begin
        while (pos < 2 * o + TAPS - 1) begin
          shift_line(16'sd0, 16'sd0);
          pos++;
        end
        emit_output(o + 1 == total);
      end
      blk_samples = 0;
      blk_outputs = 0;
      n_blocks++;
    end
  endfunction

  function automatic logic signed [15:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'sh0001;
    endcase
  endfunction

  // full scale with the sign of the tap that sample j meets in the first output
  function automatic logic signed [15:0] sat_level(int j, logic pol);
    int d;
    bit up;
    d = (j > MID_TAP) ? j - MID_TAP : MID_TAP - j;
    up = ((j % 2) == 1) ? 1'b1 : ((((d - 1) / 2) % 2) == 0);
    return (up == pol) ? 16'sh7fff : 16'sh8000;
  endfunction

  task automatic send_sample(logic signed [15:0] si, logic signed [15:0] sq, logic blk_end);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_sample_i <= si;
    in_sample_q <= sq;
    in_block_end <= blk_end;
    do @(posedge clk); while (in_stall);
    burst_left--;
    decimate_sample(si, sq, blk_end);
  endtask

  task automatic settle_and_configure(logic set);
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= set;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    coef_set = set;
    burst_left = 0;
  endtask

  task automatic random_blocks(int n_items);
    int len;
    int kind;
    int sent;
    logic signed [15:0] si;
    logic signed [15:0] sq;
    logic be;
    logic pol;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: len = $urandom_range(1, 3);
        7: len = $urandom_range(30, 40);
        8: len = TAPS;
        default: len = $urandom_range(1, 70);
      endcase
      pol = $urandom_range(0, 1);
      for (int j = 0; j < len; j++) begin
        si = 16'($urandom);
        sq = 16'($urandom);
        be = (j == len - 1);
        if (kind == 7) begin
          si = pick_extreme();
          sq = pick_extreme();
        end
        if (kind == 8) begin
          si = sat_level(j, pol);
          sq = sat_level(j, !pol);
        end
        // noise: block ends fall anywhere
        if (kind == 9) be = ($urandom_range(0, 3) == 0);
        send_sample(si, sq, be);
        sent++;
      end
    end
  endtask

  // receiver stall pattern, with one long hold-off to back up the input
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (!held_off && n_requests >= 120) begin
        out_stall <= 1'b1;
        held_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(8, 40);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          default: out_stall <= ($urandom_range(0, 99) < 80);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    iq_result_t want;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        n_requests++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_outputs.size() == 0) begin
          errors++;
          $error("unexpected result: out_i %0d out_q %0d out_last %0b", out_i, out_q, out_last);
        end else begin
          want = pending_outputs.pop_front();
          n_results++;
          if (out_i !== want.i) begin
            errors++;
            $error("out_i: expected %0d, actual %0d", want.i, out_i);
          end
          if (out_q !== want.q) begin
            errors++;
            $error("out_q: expected %0d, actual %0d", want.q, out_q);
          end
          if (out_last !== want.last) begin
            errors++;
            $error("out_last: expected %0b, actual %0b", want.last, out_last);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d results outstanding", pending_outputs.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    settle_and_configure(REMEZ_SET);
    foreach (directed_rows[r]) begin
      send_sample(directed_rows[r].i, directed_rows[r].q, directed_rows[r].blk_end);
      if (directed_rows[r].typed) begin
        void'(pending_outputs.pop_back());
        pending_outputs.push_back(directed_rows[r].want);
      end
    end
    settle_and_configure(FIRWIN_SET);
    random_blocks(140);
    settle_and_configure(REMEZ_SET);
    random_blocks(140);
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d requests in %0d blocks and checked %0d results,", n_requests,
             n_blocks, n_results);
    $display("with both coefficient sets, saturation, one-sample, short and odd blocks");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/hbd_pkg.sv
hw/rtl/hbd_cell.sv
hw/rtl/hbd_tap_sum.sv
hw/rtl/hbd_out_fifo.sv
hw/rtl/halfband_decimator_by_two.sv
tb/testbench.sv
